// ===== hw/rtl/rtdc_pkg.sv =====
// Shared constants and types for the RTD code to temperature pipeline.
package rtdc_pkg;

    localparam int TEMP_FRAC_BITS = 16;

    localparam int NUM_STAGES = 13;
    localparam int NUM_STEPS  = 4;

    localparam int H_W    = 30;
    localparam int G_W    = 36;
    localparam int LO_W   = 18;
    localparam int HI_W   = G_W - LO_W;
    localparam int PL_W   = LO_W + 1 + H_W;
    localparam int PH_W   = HI_W + H_W;
    localparam int PROD_W = G_W + H_W;
    localparam int A5_W   = 22;
    localparam int P5_W   = A5_W + H_W;

    localparam int SHIFT_A5 = 15;
    localparam int SHIFT_T  = 37 - TEMP_FRAC_BITS;
    localparam int R_W      = PROD_W - SHIFT_T;
    localparam int T_W      = R_W + 1;

    localparam logic [1:0] CFG_REF    = 2'd0;
    localparam logic [1:0] CFG_NOM    = 2'd1;
    localparam logic [1:0] CFG_KELVIN = 2'd2;

    localparam logic [15:0] REF_RESET = 16'd430;
    localparam logic [15:0] NOM_RESET = 16'd100;

    localparam logic signed [A5_W-1:0] COEF_A5 = A5_W'(64'sd1687620);
    localparam logic signed [G_W-1:0]  COEF_A4 = G_W'(64'sd1593337519);
    localparam logic signed [G_W-1:0]  COEF_A3 = G_W'(64'sd102944828);
    localparam logic signed [G_W-1:0]  COEF_A2 = G_W'(64'sd16619125);
    localparam logic signed [G_W-1:0]  COEF_A1 = G_W'(64'sd10731786);

    localparam logic signed [G_W-1:0] STEP_COEF [NUM_STEPS-1] = '{COEF_A3, COEF_A2, COEF_A1};
    localparam int STEP_SHIFT [NUM_STEPS] = '{29, 28, 27, SHIFT_T};

    localparam logic signed [31:0] H_LIMIT     = 32'sd268435456;
    localparam logic signed [31:0] H_LIMIT_NEG = -32'sd268435456;

    localparam longint KELVIN_FULL =
        (longint'(27315) * (longint'(1) << TEMP_FRAC_BITS) + longint'(50)) / longint'(100);
    localparam logic signed [T_W-1:0] KELVIN_OFFSET = T_W'(KELVIN_FULL);
    localparam logic signed [T_W-1:0] T_ZERO        = T_W'(0);
    localparam logic signed [T_W-1:0] T_MAX         = T_W'(longint'(2147483647));
    localparam logic signed [T_W-1:0] T_MIN         = T_W'(-longint'(2147483647) - longint'(1));

    localparam logic [31:0] INT32_MAX_C = 32'h7FFF_FFFF;
    localparam logic [31:0] INT32_MIN_C = 32'h8000_0000;
    localparam logic [30:0] RES_MAX_C   = 31'd2147385345;

    typedef struct packed {
        logic [30:0]           res;
        logic signed [H_W-1:0] h;
        logic                  big_pos;
        logic                  big_neg;
    } side_t;

endpackage

// ===== hw/rtl/rtd_code_to_temperature.sv =====
// RTD converter word to resistance and fixed-point temperature, pipelined.
// Accepts one item per cycle while out_stall does not back up the pipeline.
// The depth comes from the Horner evaluation: each of the four multiply and
// round steps takes a multiply stage and a round stage; all but the last add too.
// Reset clears all stage valid bits and loads the register defaults
// (reference 430 ohm, nominal 100 ohm, Celsius).
module rtd_code_to_temperature
    import rtdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] raw_rtd_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [30:0] resistance_scaled,
    output logic signed [31:0] temperature,
    output logic        saturated
);

    logic [15:0] ref_reg;
    logic [15:0] nom_reg;
    logic        kelvin_reg;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   stg_ready;

    logic [30:0]             res_reg;
    logic [30:0]             res_next;
    logic [30:0]             res1_reg;
    logic signed [31:0]      hq_reg;
    logic signed [31:0]      hq_next;
    logic signed [P5_W-1:0]  p5_reg;
    logic signed [P5_W-1:0]  p5_next;
    side_t                   side_next;
    side_t                   side_reg [2:NUM_STAGES-2];
    logic signed [G_W-1:0]   g_reg [NUM_STEPS];
    logic signed [G_W-1:0]   g4_next;
    logic signed [P5_W-1:0]  p5_rnd;
    logic signed [PL_W-1:0]  pl_reg [NUM_STEPS];
    logic signed [PH_W-1:0]  ph_reg [NUM_STEPS];
    logic signed [R_W-1:0]   r_reg;
    logic signed [T_W-1:0]   kel_off;
    logic signed [T_W-1:0]   t_next;
    logic signed [31:0]      temp_next;
    logic                    sat_next;
    logic [30:0]             resistance_scaled_reg;
    logic signed [31:0]      temperature_reg;
    logic                    saturated_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg    <= REF_RESET;
            nom_reg    <= NOM_RESET;
            kelvin_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_REF:    ref_reg    <= cfg_data;
                CFG_NOM:    nom_reg    <= cfg_data;
                CFG_KELVIN: kelvin_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        stg_ready[NUM_STAGES] = !out_stall;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            stg_ready[k] = !valid_reg[k] || stg_ready[k + 1];
        end
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            if (k == 0)
                valid_next[k] = stg_ready[k] ? in_valid : valid_reg[k];
            else
                valid_next[k] = stg_ready[k] ? valid_reg[k - 1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_stall = !stg_ready[0];

    assign res_next = 31'(raw_rtd_word[15:1] * ref_reg);
    assign hq_next  = $signed({1'b0, nom_reg, 15'b0}) - $signed({1'b0, res_reg});
    assign p5_next  = COEF_A5 * $signed(hq_reg[H_W-1:0]);

    always_comb
    begin
        side_next.res     = res1_reg;
        side_next.h       = hq_reg[H_W-1:0];
        side_next.big_pos = hq_reg > H_LIMIT;
        side_next.big_neg = hq_reg < H_LIMIT_NEG;
    end

    assign p5_rnd  = (p5_reg + P5_W'(longint'(1) <<< (SHIFT_A5 - 1))) >>> SHIFT_A5;
    assign g4_next = COEF_A4 + p5_rnd[G_W-1:0];

    always_ff @(posedge clk)
    begin
        if (stg_ready[0])
            res_reg <= res_next;
        if (stg_ready[1])
        begin
            hq_reg   <= hq_next;
            res1_reg <= res_reg;
        end
        if (stg_ready[2])
        begin
            p5_reg      <= p5_next;
            side_reg[2] <= side_next;
        end
        if (stg_ready[3])
            g_reg[0] <= g4_next;
    end

    for (genvar k = 3; k <= NUM_STAGES - 2; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (stg_ready[k])
                side_reg[k] <= side_reg[k - 1];
        end
    end

    for (genvar j = 0; j < NUM_STEPS; j++)
    begin : g_step
        localparam int MK = 4 + 2 * j;
        localparam int AK = MK + 1;
        localparam logic signed [PROD_W-1:0] HALF =
            PROD_W'(longint'(1) <<< (STEP_SHIFT[j] - 1));

        logic signed [LO_W:0]     lo_op;
        logic signed [HI_W-1:0]   hi_op;
        logic signed [PL_W-1:0]   pl_next;
        logic signed [PH_W-1:0]   ph_next;
        logic signed [PROD_W-1:0] prod_sum;
        logic signed [PROD_W-1:0] rnd_sum;
        logic signed [PROD_W-1:0] rnd_val;

        assign lo_op   = $signed({1'b0, g_reg[j][LO_W-1:0]});
        assign hi_op   = g_reg[j][G_W-1:LO_W];
        assign pl_next = lo_op * side_reg[MK - 1].h;
        assign ph_next = hi_op * side_reg[MK - 1].h;

        assign prod_sum = (PROD_W'(ph_reg[j]) <<< LO_W) + PROD_W'(pl_reg[j]);
        assign rnd_sum  = prod_sum + HALF;
        assign rnd_val  = rnd_sum >>> STEP_SHIFT[j];

        always_ff @(posedge clk)
        begin
            if (stg_ready[MK])
            begin
                pl_reg[j] <= pl_next;
                ph_reg[j] <= ph_next;
            end
        end

        if (j < NUM_STEPS - 1)
        begin : g_acc
            always_ff @(posedge clk)
            begin
                if (stg_ready[AK])
                    g_reg[j + 1] <= STEP_COEF[j] + rnd_val[G_W-1:0];
            end
        end
        else
        begin : g_last
            always_ff @(posedge clk)
            begin
                if (stg_ready[AK])
                    r_reg <= rnd_val[R_W-1:0];
            end
        end
    end

    assign kel_off = kelvin_reg ? KELVIN_OFFSET : T_ZERO;
    assign t_next  = kel_off - T_W'(r_reg);

    always_comb
    begin
        sat_next  = 1'b1;
        temp_next = $signed(INT32_MIN_C);
        if (side_reg[NUM_STAGES-2].big_pos)
            temp_next = $signed(INT32_MIN_C);
        else if (side_reg[NUM_STAGES-2].big_neg)
            temp_next = $signed(INT32_MAX_C);
        else if (t_next > T_MAX)
            temp_next = $signed(INT32_MAX_C);
        else if (t_next < T_MIN)
            temp_next = $signed(INT32_MIN_C);
        else
        begin
            temp_next = t_next[31:0];
            sat_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_ready[NUM_STAGES-1])
        begin
            resistance_scaled_reg <= side_reg[NUM_STAGES-2].res;
            temperature_reg       <= temp_next;
            saturated_reg         <= sat_next;
        end
    end

    assign out_valid         = valid_reg[NUM_STAGES-1];
    assign resistance_scaled = resistance_scaled_reg;
    assign temperature       = temperature_reg;
    assign saturated         = saturated_reg;

endmodule

// ===== hw/rtl/rtdc_checker.sv =====
// Port-level assertions for the RTD temperature pipeline and their bind.
module rtdc_checker
    import rtdc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [30:0] resistance_scaled,
    input logic signed [31:0] temperature,
    input logic        saturated
);

    localparam int CNT_W = $clog2(NUM_STAGES + 2);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             in_xfer;
    logic             out_xfer;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;
    assign cnt_next = cnt_reg + CNT_W'(in_xfer) - CNT_W'(out_xfer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(temperature)
            && $stable(resistance_scaled) && $stable(saturated))
        else $error("Stalled output transfer changed.");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> temperature == $signed(INT32_MAX_C)
            || temperature == $signed(INT32_MIN_C))
        else $error("Saturated flag set without a clipped temperature.");

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(NUM_STAGES))
        else $error("More items in flight than pipeline stages.");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != '0)
        else $error("Output valid with no input transfer outstanding.");

endmodule

bind rtd_code_to_temperature rtdc_checker u_rtdc_checker (.*);

// ===== sim/rtd_code_to_temperature_tb.sv =====
// Testbench for rtd_code_to_temperature: directed and random words checked against a predictor or tabled results.
`timescale 1ns / 1ps

module rtd_code_to_temperature_tb;

    import rtdc_pkg::CFG_REF;
    import rtdc_pkg::CFG_NOM;
    import rtdc_pkg::CFG_KELVIN;

    localparam int     FRAC          = 16;
    localparam longint POLY_A1       = 64'sd10731786;
    localparam longint POLY_A2       = 64'sd16619125;
    localparam longint POLY_A3       = 64'sd102944828;
    localparam longint POLY_A4       = 64'sd1593337519;
    localparam longint POLY_A5       = 64'sd1687620;
    localparam longint H_BOUND       = 64'sd1 <<< 28;
    localparam longint KELVIN_Q      = (64'sd27315 * (64'sd1 <<< FRAC) + 64'sd50) / 64'sd100;
    localparam longint TEMP_MAX      = 64'sd2147483647;
    localparam longint TEMP_MIN      = -64'sd2147483648;
    localparam int     PIPE_LATENCY  = 13;
    localparam int     CYCLE_LIMIT   = 500000;
    localparam int     SEGMENT_WORDS = 210;
    localparam int     NUM_SEGMENTS  = 8;
    localparam int     NUM_DIRECTED  = 25;

    typedef struct packed {
        logic [30:0]        res;
        logic signed [31:0] temp;
        logic               sat;
    } reading_t;

    typedef struct packed {
        logic [15:0]        ref_ohm;
        logic [15:0]        nom_ohm;
        logic               kelvin;
        logic [15:0]        word;
        logic               typed;
        logic [30:0]        res;
        logic signed [31:0] temp;
        logic               sat;
    } vector_t;

    localparam vector_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{16'd430,   16'd100,   1'b0, 16'h0000,  1'b0, 31'd0,          32'h0,        1'b0},
        '{16'd430,   16'd100,   1'b0, 16'h0001,  1'b0, 31'd0,          32'h0,        1'b0},
        '{16'd430,   16'd100,   1'b0, 16'hFFFF,  1'b0, 31'd0,          32'h0,        1'b0},
        '{16'd430,   16'd100,   1'b0, 16'h7FFF,  1'b0, 31'd0,          32'h0,        1'b0},
        '{16'd430,   16'd100,   1'b0, 16'h8000,  1'b0, 31'd0,          32'h0,        1'b0},
        '{16'd430,   16'd100,   1'b0, 16'h5555,  1'b0, 31'd0,          32'h0,        1'b0},
        '{16'd430,   16'd100,   1'b0, 16'hAAAA,  1'b0, 31'd0,          32'h0,        1'b0},
        '{16'd32768, 16'd100,   1'b0, 16'd200,   1'b1, 31'd3276800,    32'h0,        1'b0},
        '{16'd32768, 16'd100,   1'b0, 16'd201,   1'b1, 31'd3276800,    32'h0,        1'b0},
        '{16'd32768, 16'd100,   1'b0, 16'd202,   1'b0, 31'd0,          32'h0,        1'b0},
        '{16'd32768, 16'd100,   1'b0, 16'd198,   1'b0, 31'd0,          32'h0,        1'b0},
        '{16'd32768, 16'd100,   1'b0, 16'd16584, 1'b0, 31'd0,          32'h0,        1'b0},
        '{16'd32768, 16'd100,   1'b0, 16'd16586, 1'b1, 31'd271745024,  32'h7FFFFFFF, 1'b1},
        '{16'd32768, 16'd100,   1'b1, 16'd200,   1'b1, 31'd3276800,    32'd17901158, 1'b0},
        '{16'd32768, 16'd100,   1'b1, 16'd201,   1'b1, 31'd3276800,    32'd17901158, 1'b0},
        '{16'd32768, 16'd8292,  1'b0, 16'd200,   1'b0, 31'd0,          32'h0,        1'b0},
        '{16'd32768, 16'd8292,  1'b0, 16'd198,   1'b1, 31'd3244032,    32'h80000000, 1'b1},
        '{16'd65535, 16'd1,     1'b0, 16'hFFFF,  1'b1, 31'd2147385345, 32'h7FFFFFFF, 1'b1},
        '{16'd65535, 16'd1,     1'b0, 16'hFFFE,  1'b1, 31'd2147385345, 32'h7FFFFFFF, 1'b1},
        '{16'd65535, 16'd1,     1'b0, 16'h0000,  1'b0, 31'd0,          32'h0,        1'b0},
        '{16'd1,     16'd65535, 1'b1, 16'h0000,  1'b1, 31'd0,          32'h80000000, 1'b1},
        '{16'd1,     16'd65535, 1'b1, 16'hFFFF,  1'b1, 31'd32767,      32'h80000000, 1'b1},
        '{16'd1,     16'd1,     1'b0, 16'hFFFF,  1'b0, 31'd0,          32'h0,        1'b0},
        '{16'd0,     16'd0,     1'b0, 16'hFFFF,  1'b1, 31'd0,          32'h0,        1'b0},
        '{16'd0,     16'd100,   1'b1, 16'h1234,  1'b0, 31'd0,          32'h0,        1'b0}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = CFG_REF;
    logic [15:0]        cfg_data = 16'd0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [15:0]        raw_rtd_word = 16'd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [30:0]        resistance_scaled;
    logic signed [31:0] temperature;
    logic               saturated;

    logic [15:0] cfg_ref = 16'd430;
    logic [15:0] cfg_nom = 16'd100;
    logic        cfg_kelvin = 1'b0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_cycles = 0;
    int          failures = 0;
    int          cycles = 0;
    reading_t    pending_readings [$];

    rtd_code_to_temperature u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .raw_rtd_word      (raw_rtd_word),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .resistance_scaled (resistance_scaled),
        .temperature       (temperature),
        .saturated         (saturated)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic longint round_shift(input longint x, input int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic reading_t rtd_convert(input logic [15:0] word);
        reading_t r;
        longint   ohms_q;
        longint   hq;
        longint   g;
        longint   t;
        ohms_q = longint'(word[15:1]) * longint'(cfg_ref);
        hq = (longint'(cfg_nom) <<< 15) - ohms_q;
        r.res = ohms_q[30:0];
        r.sat = 1'b0;
        if (hq > H_BOUND)
        begin
            t = TEMP_MIN;
            r.sat = 1'b1;
        end
        else if (hq < -H_BOUND)
        begin
            t = TEMP_MAX;
            r.sat = 1'b1;
        end
        else
        begin
            g = POLY_A4 + round_shift(POLY_A5 * hq, 15);
            g = POLY_A3 + round_shift(g * hq, 29);
            g = POLY_A2 + round_shift(g * hq, 28);
            g = POLY_A1 + round_shift(g * hq, 27);
            t = -round_shift(g * hq, 37 - FRAC);
            if (cfg_kelvin)
                t = t + KELVIN_Q;
            if (t > TEMP_MAX)
            begin
                t = TEMP_MAX;
                r.sat = 1'b1;
            end
            else if (t < TEMP_MIN)
            begin
                t = TEMP_MIN;
                r.sat = 1'b1;
            end
        end
        r.temp = t[31:0];
        return r;
    endfunction

    // Half the words are uniform (all when cfg_ref is 0); the rest sit near zero deviation or the clip edges.
    function automatic logic [15:0] pick_word();
        longint base;
        longint code;
        int     sel;
        sel = $urandom_range(0, 3);
        if (sel < 2 || cfg_ref == 16'd0)
            return 16'($urandom);
        base = longint'(cfg_nom) <<< 15;
        if (sel == 3)
            base = ($urandom_range(0, 1) != 0) ? base + H_BOUND : base - H_BOUND;
        code = base / longint'(cfg_ref) + longint'($urandom_range(0, 16)) - 64'sd8;
        if (code < 0)
            code = 0;
        else if (code > 32767)
            code = 32767;
        return {code[14:0], 1'($urandom)};
    endfunction

    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input logic [15:0] ref_ohm, input logic [15:0] nom_ohm,
                                  input logic [15:0] kelvin_data);
        write_reg(CFG_REF, ref_ohm);
        write_reg(CFG_NOM, nom_ohm);
        write_reg(CFG_KELVIN, kelvin_data);
        cfg_valid <= 1'b0;
        cfg_ref = ref_ohm;
        cfg_nom = nom_ohm;
        cfg_kelvin = kelvin_data[0];
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (2 * PIPE_LATENCY) @(posedge clk);
    endtask

    task automatic send_word(input logic [15:0] word, input reading_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_rtd_word <= word;
        do @(posedge clk); while (in_stall);
        pending_readings.push_back(want);
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles--;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_readings.size() == 0)
            begin
                $display("%0t: unexpected transfer, actual res %0d temp %0d sat %0b",
                         $time, resistance_scaled, temperature, saturated);
                failures++;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (resistance_scaled !== want.res)
                begin
                    $display("%0t: resistance_scaled expected %0d actual %0d",
                             $time, want.res, resistance_scaled);
                    failures++;
                end
                if (temperature !== want.temp)
                begin
                    $display("%0t: temperature expected %0d actual %0d",
                             $time, want.temp, temperature);
                    failures++;
                end
                if (saturated !== want.sat)
                begin
                    $display("%0t: saturated expected %0b actual %0b",
                             $time, want.sat, saturated);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        vector_t     row;
        reading_t    want;
        logic [15:0] ref_ohm;
        logic [15:0] nom_ohm;
        logic [15:0] kelvin_data;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (row.ref_ohm != cfg_ref || row.nom_ohm != cfg_nom || row.kelvin != cfg_kelvin)
            begin
                drain();
                apply_settings(row.ref_ohm, row.nom_ohm, {15'd0, row.kelvin});
            end
            if (row.typed)
                want = '{res: row.res, temp: row.temp, sat: row.sat};
            else
                want = rtd_convert(row.word);
            send_word(row.word, want);
        end

        for (int seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            drain();
            kelvin_data = {15'($urandom), 1'($urandom)};
            case (seg)
                0: begin ref_ohm = 16'd430; nom_ohm = 16'd100; kelvin_data[0] = 1'b0; end
                1: begin ref_ohm = 16'd430; nom_ohm = 16'd100; kelvin_data[0] = 1'b1; end
                2: begin ref_ohm = 16'hFFFF; nom_ohm = 16'hFFFF; kelvin_data[0] = 1'b0; end
                3: begin ref_ohm = 16'd1; nom_ohm = 16'd1; kelvin_data[0] = 1'b1; end
                5: begin
                    ref_ohm = 16'($urandom_range(380, 480));
                    nom_ohm = 16'($urandom_range(90, 1100));
                end
                6: begin ref_ohm = 16'hFFFF; nom_ohm = 16'd1; kelvin_data[0] = 1'b1; end
                default: begin
                    ref_ohm = 16'($urandom_range(1, 65535));
                    nom_ohm = 16'($urandom);
                end
            endcase
            apply_settings(ref_ohm, nom_ohm, kelvin_data);
            case (seg % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 54; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 54; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            // The output side holds off while words keep coming, so the pipeline backs up.
            if (seg == 4)
                hold_cycles = 300;
            for (int n = 0; n < SEGMENT_WORDS; n++)
            begin
                row.word = pick_word();
                send_word(row.word, rtd_convert(row.word));
            end
        end

        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
